// ===== rtl/cd_audio_lpcm_pes_packetizer_assert.svh =====
// ----------------------------------------------------------------------------
// cd audio lpcm pes packetizer assertion macros
// shared concurrent assertion forms, reset-qualified, reporting by $error
// ----------------------------------------------------------------------------
`ifndef CD_AUDIO_LPCM_PES_PACKETIZER_ASSERT_SVH
`define CD_AUDIO_LPCM_PES_PACKETIZER_ASSERT_SVH

// condition holds at every clock edge out of reset
`define CDLP_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("cdlp invariant violated");

// antecedent in a cycle implies consequent in the same cycle
`define CDLP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cdlp implication violated");

// antecedent in a cycle implies consequent in the next cycle
`define CDLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cdlp sequence violated");

`endif

// ===== rtl/cdlp_pkg.sv =====
// ----------------------------------------------------------------------------
// cdlp_pkg
// shared types, header constants and the header byte table
// ----------------------------------------------------------------------------
package cdlp_pkg;

    localparam int SECTOR_BYTES = 2352;
    localparam int HEADER_BYTES = 16;
    localparam int QUEUE_DEPTH  = 4;

    // header field values
    localparam logic [7:0] HDR_ZERO      = 8'h00;
    localparam logic [7:0] HDR_PREFIX    = 8'h01;
    localparam logic [7:0] HDR_STREAM_ID = 8'hBD;
    localparam logic [7:0] HDR_FLAGS     = 8'h80;
    localparam logic [7:0] HDR_SUB_ID    = 8'hA0;
    localparam logic [7:0] HDR_FRAME     = 8'hFF;
    localparam logic [7:0] HDR_AUDIO     = 8'h21;
    localparam logic [7:0] HDR_QUANT     = 8'h80;
    localparam logic [15:0] LEN_EXTRA    = 16'd10;

    // sequencer byte positions
    typedef logic [4:0] t_idx;
    localparam t_idx IDX_FIRST = 5'd0;
    localparam t_idx IDX_HI    = 5'd16;
    localparam t_idx IDX_LO    = 5'd17;

    // one classified word, front to back
    typedef struct packed {
        logic        hdr;
        logic [15:0] len;
        logic [15:0] word;
        logic        hi_end;
        logic        has_lo;
        logic        lo_end;
    } t_cmd;

    // fixed packet header, length field in bytes four and five
    function automatic logic [7:0] hdr_byte(input logic [3:0] pos, input logic [15:0] len);
        logic [7:0] b;
        unique case (pos)
            4'd0:    b = HDR_ZERO;
            4'd1:    b = HDR_ZERO;
            4'd2:    b = HDR_PREFIX;
            4'd3:    b = HDR_STREAM_ID;
            4'd4:    b = len[15:8];
            4'd5:    b = len[7:0];
            4'd6:    b = HDR_FLAGS;
            4'd7:    b = HDR_ZERO;
            4'd8:    b = HDR_ZERO;
            4'd9:    b = HDR_SUB_ID;
            4'd10:   b = HDR_FRAME;
            4'd11:   b = HDR_ZERO;
            4'd12:   b = HDR_ZERO;
            4'd13:   b = HDR_ZERO;
            4'd14:   b = HDR_AUDIO;
            default: b = HDR_QUANT;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/cdlp_front.sv =====
// ----------------------------------------------------------------------------
// cdlp_front
// accepts sample words, tracks chunk and packet counts, classifies each word
// ----------------------------------------------------------------------------
module cdlp_front import cdlp_pkg::*; #(
    parameter int MAX_READ_SECTORS = 24,
    parameter int PACKET_BYTES     = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_chunk_start,
    input  logic [15:0] i_chunk_bytes,
    input  logic [15:0] i_sample_word,
    input  logic        i_queue_full,
    output logic        o_push,
    output t_cmd        o_cmd
);

    localparam int MAX_PAYLOAD_I = PACKET_BYTES - HEADER_BYTES;
    localparam int MAX_CHUNK_I   = SECTOR_BYTES * MAX_READ_SECTORS;
    localparam int PW            = $clog2(MAX_PAYLOAD_I + 1);
    localparam logic [15:0] LP_MAX_PAYLOAD = 16'(MAX_PAYLOAD_I);
    localparam logic [15:0] LP_MAX_CHUNK   = 16'(MAX_CHUNK_I);

    logic [15:0]   r_chunk_left, n_chunk_left;
    logic [PW-1:0] r_packet_left, n_packet_left;

    logic [15:0]   eff_chunk, c1, c2;
    logic [PW-1:0] eff_pkt, pkt0, p1, p2;
    logic          accept, drop, hdr, has_lo;

    assign o_ready = i_rst_n && !i_queue_full;
    assign accept  = i_valid && o_ready;

    // classify the word against the running counts
    always_comb begin
        if (i_chunk_start) begin
            eff_chunk = (i_chunk_bytes > LP_MAX_CHUNK) ? LP_MAX_CHUNK : i_chunk_bytes;
            eff_pkt   = '0;
        end else begin
            eff_chunk = r_chunk_left;
            eff_pkt   = r_packet_left;
        end
        drop = (eff_chunk == 16'd0);
        hdr  = (eff_pkt == '0);
        if (hdr) begin
            pkt0 = (eff_chunk < LP_MAX_PAYLOAD) ? PW'(eff_chunk) : PW'(LP_MAX_PAYLOAD);
        end else begin
            pkt0 = eff_pkt;
        end
        c1     = eff_chunk - 16'd1;
        p1     = pkt0 - PW'(1);
        has_lo = (c1 != 16'd0) && (p1 != '0);
        c2     = has_lo ? (c1 - 16'd1) : c1;
        p2     = has_lo ? (p1 - PW'(1)) : p1;
        n_chunk_left  = drop ? eff_chunk : c2;
        n_packet_left = drop ? eff_pkt : p2;
    end

    // command to the back end
    always_comb begin
        o_push       = accept && !drop;
        o_cmd.hdr    = hdr;
        o_cmd.len    = 16'(pkt0) + LEN_EXTRA;
        o_cmd.word   = i_sample_word;
        o_cmd.hi_end = (p1 == '0);
        o_cmd.has_lo = has_lo;
        o_cmd.lo_end = (p2 == '0);
    end

    // count state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_left  <= '0;
            r_packet_left <= '0;
        end else if (accept) begin
            r_chunk_left  <= n_chunk_left;
            r_packet_left <= n_packet_left;
        end
    end

`include "cd_audio_lpcm_pes_packetizer_assert.svh"

    // counts stay within their saturation bounds
    `CDLP_ASSERT_ALWAYS(a_chunk_bound, i_clk, i_rst_n, r_chunk_left <= LP_MAX_CHUNK)
    `CDLP_ASSERT_ALWAYS(a_pkt_bound, i_clk, i_rst_n, 16'(r_packet_left) <= LP_MAX_PAYLOAD)
    // an open packet never owes more than the chunk still holds
    `CDLP_ASSERT_IMPLY(a_pkt_in_chunk, i_clk, i_rst_n, r_packet_left != '0,
                       16'(r_packet_left) <= r_chunk_left)

endmodule

// ===== rtl/cdlp_queue.sv =====
// ----------------------------------------------------------------------------
// cdlp_queue
// short register queue of classified words between front and back
// ----------------------------------------------------------------------------
module cdlp_queue import cdlp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_slot [QUEUE_DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];

    // slot storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

`include "cd_audio_lpcm_pes_packetizer_assert.svh"

    // no overflow and no underflow
    `CDLP_ASSERT_IMPLY(a_no_overflow, i_clk, i_rst_n, o_full, !i_push || i_pop)
    `CDLP_ASSERT_IMPLY(a_no_underflow, i_clk, i_rst_n, !o_valid, !i_pop)

endmodule

// ===== rtl/cdlp_back.sv =====
// ----------------------------------------------------------------------------
// cdlp_back
// byte sequencer: header, then swapped payload, into the output register
// ----------------------------------------------------------------------------
module cdlp_back import cdlp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_cmd       i_q_cmd,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_packet_end,
    output logic       o_run_end
);

    logic       r_busy;
    t_cmd       r_cmd;
    t_idx       r_idx;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_pend;
    logic       r_out_run;

    logic       can_load, step, at_last;
    t_idx       last_idx, q_start_idx;
    logic [7:0] n_byte;
    logic       n_pend;

    assign o_valid      = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_packet_end = r_out_pend;
    assign o_run_end    = r_out_run;

    assign can_load    = !r_out_valid || i_ready;
    assign step        = can_load && r_busy;
    assign last_idx    = r_cmd.has_lo ? IDX_LO : IDX_HI;
    assign at_last     = (r_idx == last_idx);
    assign q_start_idx = i_q_cmd.hdr ? IDX_FIRST : IDX_HI;
    assign o_pop       = i_q_valid && (!r_busy || (step && at_last));

    // byte at the current position
    always_comb begin
        if (r_idx == IDX_HI) begin
            n_byte = r_cmd.word[15:8];
            n_pend = r_cmd.hi_end;
        end else if (r_idx == IDX_LO) begin
            n_byte = r_cmd.word[7:0];
            n_pend = r_cmd.lo_end;
        end else begin
            n_byte = hdr_byte(r_idx[3:0], r_cmd.len);
            n_pend = 1'b0;
        end
    end

    // output word register, no reset on payload
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_byte <= n_byte;
            r_out_pend <= n_pend;
            r_out_run  <= at_last;
        end
    end

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= IDX_FIRST;
            r_out_valid <= 1'b0;
        end else begin
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= q_start_idx;
            end else if (step) begin
                if (at_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + 5'd1;
                end
            end
        end
    end

    // command register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_q_cmd;
        end
    end

`include "cd_audio_lpcm_pes_packetizer_assert.svh"

    // position never runs past the last byte of the command
    `CDLP_ASSERT_IMPLY(a_idx_bound, i_clk, i_rst_n, r_busy, r_idx <= last_idx)
    // headerless commands start straight at the payload
    `CDLP_ASSERT_IMPLY(a_no_hdr_skip, i_clk, i_rst_n, r_busy && !r_cmd.hdr, r_idx >= IDX_HI)
    // a pop while busy only happens on the final byte
    `CDLP_ASSERT_NEXT(a_pop_reload, i_clk, i_rst_n, o_pop && r_busy, r_busy)

endmodule

// ===== rtl/cd_audio_lpcm_pes_packetizer.sv =====
// ----------------------------------------------------------------------------
// cd_audio_lpcm_pes_packetizer
// cd audio sample words in, lpcm pes packet byte stream out
// ----------------------------------------------------------------------------
// Input channel: i_valid/o_ready carry one 16-bit sample word, with a chunk
// start flag and the chunk byte length on the first word of a read chunk.
// Output channel: o_valid/i_ready carry one byte per word, with packet_end on
// the last payload byte of a packet and run_end on the last byte of a word.
// Each payload word gives two bytes (one at an odd chunk end or packet end);
// a word that opens a packet first gives the 16-byte header. Words outside a
// chunk are accepted and dropped.
// An accepted word passes through a queue slot and the command register
// before its first byte is loaded into the output register. Throughput:
// the output register emits one byte per cycle while the receiver is ready;
// the byte sequencer is the limit. A four-entry word queue lets the input
// keep accepting while the receiver stalls; o_ready drops only once full.
// Reset (synchronous, active low) clears the chunk and packet counts, the
// queue and the output valid flag; o_ready is low while reset is held.
// ----------------------------------------------------------------------------
module cd_audio_lpcm_pes_packetizer import cdlp_pkg::*; #(
    parameter int MAX_READ_SECTORS = 24,
    parameter int PACKET_BYTES     = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_chunk_start,
    input  logic [15:0] i_chunk_bytes,
    input  logic [15:0] i_sample_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_packet_end,
    output logic        o_run_end
);

    logic push, pop, q_full, q_valid;
    t_cmd front_cmd, q_cmd;

    // classification front end
    cdlp_front #(
        .MAX_READ_SECTORS (MAX_READ_SECTORS),
        .PACKET_BYTES     (PACKET_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_chunk_start (i_chunk_start),
        .i_chunk_bytes (i_chunk_bytes),
        .i_sample_word (i_sample_word),
        .i_queue_full  (q_full),
        .o_push        (push),
        .o_cmd         (front_cmd)
    );

    // word queue
    cdlp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // byte sequencer back end
    cdlp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_cmd      (q_cmd),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_packet_end (o_packet_end),
        .o_run_end    (o_run_end)
    );

endmodule
